// ===== rtl/isqs_pkg.sv =====
// ----------------------------------------------------------------------------
// isqs_pkg
// Request codes, status codes and the control types that are shared between
// the controller, the cells and the top level of the indexed sequence store.
// ----------------------------------------------------------------------------
package isqs_pkg;

	localparam int REQ_W = 3;
	localparam int POS_W = 6;
	localparam int IN_WORD_W = 32;
	localparam int OUT_WORD_W = 32;
	localparam int OCC_W = 7;

	localparam logic [REQ_W-1:0] REQ_GET = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_POP = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_INDEX = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_SHIFT
	} cell_cmd_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_POS,
		RD_FRONT
	} rd_src_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		cell_cmd_t        cmd;
		logic [POS_W-1:0] pos;
	} cell_op_t;

	// result control from the controller to the output stage
	typedef struct packed {
		status_t status;
		rd_src_t rd_src;
	} ctrl_t;

endpackage

// ===== rtl/isqs_cell.sv =====
// ----------------------------------------------------------------------------
// isqs_cell
// One storage cell of the row: holds the word at its own position and moves
// it to or from its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module isqs_cell #(
	parameter int WORD_WIDTH = 32,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  isqs_pkg::cell_op_t       cell_op,
	input  logic [WORD_WIDTH-1:0]    write_word,
	input  logic [WORD_WIDTH-1:0]    left_word,
	input  logic [WORD_WIDTH-1:0]    right_word,
	output logic [WORD_WIDTH-1:0]    word,
	output logic [WORD_WIDTH-1:0]    sel_word
);
	import isqs_pkg::*;

	localparam int IDX_W = $clog2(IDX + 2);
	localparam int CMPW = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

	logic [WORD_WIDTH-1:0] word_q;
	logic [CMPW-1:0]       pos_ext;
	logic                  at_pos;
	logic                  past_pos;

	assign pos_ext = CMPW'(cell_op.pos);
	assign at_pos = (MY_IDX == pos_ext);
	assign past_pos = (MY_IDX > pos_ext);

	always_ff @(posedge clk) begin
		case (cell_op.cmd)
			CELL_WRITE: begin
				if (at_pos) word_q <= write_word;
			end
			CELL_INSERT: begin
				if (at_pos) word_q <= write_word;
				else if (past_pos) word_q <= left_word;
			end
			CELL_SHIFT: begin
				if (at_pos || past_pos) word_q <= right_word;
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;
	// gated copy for the read or-tree
	assign sel_word = at_pos ? word_q : '0;

endmodule

// ===== rtl/isqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// isqs_ctrl
// Request decoder and element counter: checks the position against the
// count, picks the cell command and the status of the result beat.
// ----------------------------------------------------------------------------
module isqs_ctrl #(
	parameter int CAPACITY = 64,
	parameter int CW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [isqs_pkg::REQ_W-1:0] req_type,
	input  logic [isqs_pkg::POS_W-1:0] position,
	output isqs_pkg::cell_op_t         cell_op,
	output isqs_pkg::ctrl_t            ctrl,
	output logic [CW-1:0]              count,
	output logic [CW-1:0]              count_next
);
	import isqs_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          pos_lt;
	logic          pos_zero;
	logic          full;
	logic          empty;

	assign pos_lt = CMPW'(position) < CMPW'(count_q);
	assign pos_zero = (position == '0);
	assign full = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		cell_op.cmd = CELL_HOLD;
		cell_op.pos = position;
		ctrl.status = ST_DONE;
		ctrl.rd_src = RD_NONE;
		count_d = count_q;
		case (req_type)
			REQ_GET: begin
				if (pos_lt) ctrl.rd_src = RD_POS;
				else ctrl.status = ST_INDEX;
			end
			REQ_SET: begin
				if (pos_lt) cell_op.cmd = CELL_WRITE;
				else ctrl.status = ST_INDEX;
			end
			REQ_INSERT: begin
				// index check before the full check
				if (!(pos_lt || pos_zero)) begin
					ctrl.status = ST_INDEX;
				end else if (full) begin
					ctrl.status = ST_FULL;
				end else begin
					cell_op.cmd = CELL_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			REQ_REMOVE: begin
				if (pos_lt) begin
					cell_op.cmd = CELL_SHIFT;
					count_d = count_q - CW'(1);
				end else begin
					ctrl.status = ST_INDEX;
				end
			end
			REQ_POP: begin
				if (empty) begin
					ctrl.status = ST_EMPTY;
				end else begin
					ctrl.rd_src = RD_FRONT;
					cell_op.cmd = CELL_SHIFT;
					cell_op.pos = '0;
					count_d = count_q - CW'(1);
				end
			end
			REQ_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		if (!accept) cell_op.cmd = CELL_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	assign count = count_q;
	assign count_next = count_d;

endmodule

// ===== rtl/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered store of up to CAPACITY words addressed by position, built as a
// row of cells that shift their words together on insert and remove.
//
// Usage:
//   Request beats (req_type, position, write_value) enter on in_valid /
//   in_stall; each one gives exactly one result beat (status, read_value,
//   occupancy) on out_valid / out_stall, in request order.
//   A request is decoded and applied to the whole cell row in the cycle it
//   is accepted, and its result sits in the output register from the next
//   cycle. The store takes one request per cycle while results are taken.
//   The row update and the read or-tree over all cells set the cycle.
//   While a result beat is held by out_stall, in_stall is raised and no
//   further request is taken; a beat taken in the same cycle frees the slot.
//   Reset empties the store (count zero, no result pending); the cell words
//   are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
	parameter int CAPACITY = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [isqs_pkg::REQ_W-1:0]      req_type,
	input  logic [isqs_pkg::POS_W-1:0]      position,
	input  logic [isqs_pkg::IN_WORD_W-1:0]  write_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [isqs_pkg::OUT_WORD_W-1:0] read_value,
	output logic [isqs_pkg::OCC_W-1:0]      occupancy
);
	import isqs_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic                  accept;
	logic                  out_valid_q;
	cell_op_t              cell_op;
	ctrl_t                 ctrl;
	logic [CW-1:0]         count;
	logic [CW-1:0]         count_next;
	logic [WORD_WIDTH-1:0] write_word;
	logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
	logic [WORD_WIDTH-1:0] cell_sel [CAPACITY];
	logic [WORD_WIDTH-1:0] pos_word;
	logic [WORD_WIDTH-1:0] rd_word;
	status_t               status_q;
	logic [OUT_WORD_W-1:0] read_value_q;
	logic [OCC_W-1:0]      occupancy_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign write_word = WORD_WIDTH'(write_value);

	isqs_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.position   (position),
		.cell_op    (cell_op),
		.ctrl       (ctrl),
		.count      (count),
		.count_next (count_next)
	);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_w = cell_word[k];
		end else begin : g_mid_r
			assign right_w = cell_word[k+1];
		end

		isqs_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.IDX        (k)
		) u_cell (
			.clk        (clk),
			.cell_op    (cell_op),
			.write_word (write_word),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[k]),
			.sel_word   (cell_sel[k])
		);
	end

	// only the addressed cell passes its word, so an or over the row reads it
	always_comb begin
		pos_word = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			pos_word = pos_word | cell_sel[k];
		end
	end

	always_comb begin
		case (ctrl.rd_src)
			RD_POS:   rd_word = pos_word;
			RD_FRONT: rd_word = cell_word[0];
			default:  rd_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= ctrl.status;
			read_value_q <= OUT_WORD_W'(rd_word);
			occupancy_q <= OCC_W'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign occupancy = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctrl.status == ST_FULL |=> count == CW'(CAPACITY))
		else $error("full status with room left");

	a_empty_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctrl.status == ST_EMPTY |=> read_value == '0 && count == '0)
		else $error("empty status with words stored or data read");

	a_index_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctrl.status == ST_INDEX |=> $stable(count) && read_value == '0)
		else $error("index error changed the store or returned data");

	a_grow_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cell_op.cmd == CELL_INSERT |=> count == $past(count) + CW'(1))
		else $error("insert did not grow the count by one");

endmodule

// ===== dv/tb_indexed_sequence_store.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_indexed_sequence_store
// Self-checking bench for the indexed sequence store. A directed run covers
// the empty, bad-index, refused-append and unused-request cases. Phases of
// random traffic then grow the store to full, shrink it and churn it, while
// both handshakes idle and stall at random. A scoreboard keeps its own copy
// of the store and checks every result beat against it.
// ---------------------------------------------------------------------------
module tb_indexed_sequence_store;
	import isqs_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int MISMATCH_REPORTS = 10;
	localparam int PHASES = 7;
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	typedef struct {
		logic [REQ_W-1:0]     kind;
		logic [POS_W-1:0]     pos;
		logic [IN_WORD_W-1:0] value;
	} request_t;

	typedef struct {
		logic [1:0]            status;
		logic [OUT_WORD_W-1:0] word;
		logic [OCC_W-1:0]      occ;
	} result_t;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_ROUGH} traffic_mix_t;

	class store_scoreboard;
		logic [OUT_WORD_W-1:0] words [STORE_DEPTH];
		int count;
		int faults;
		result_t awaited [$];

		function new();
			count = 0;
			faults = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int stored();
			return count;
		endfunction

		// apply one accepted request to the shadow store and queue its result
		function void note_request(request_t r);
			result_t exp;
			int k;
			exp.status = ST_DONE;
			exp.word = '0;
			case (r.kind)
			REQ_GET: begin
				if (r.pos < count)
					exp.word = words[r.pos];
				else
					exp.status = ST_INDEX;
			end
			REQ_SET: begin
				if (r.pos < count)
					words[r.pos] = r.value;
				else
					exp.status = ST_INDEX;
			end
			REQ_INSERT: begin
				// index check wins over the full check
				if (!(r.pos < count || r.pos == 0)) begin
					exp.status = ST_INDEX;
				end else if (count >= STORE_DEPTH) begin
					exp.status = ST_FULL;
				end else begin
					for (k = count; k > r.pos; k--)
						words[k] = words[k - 1];
					words[r.pos] = r.value;
					count++;
				end
			end
			REQ_REMOVE: begin
				if (r.pos < count) begin
					for (k = r.pos; k + 1 < count; k++)
						words[k] = words[k + 1];
					count--;
				end else begin
					exp.status = ST_INDEX;
				end
			end
			REQ_POP: begin
				if (count == 0) begin
					exp.status = ST_EMPTY;
				end else begin
					exp.word = words[0];
					for (k = 0; k + 1 < count; k++)
						words[k] = words[k + 1];
					count--;
				end
			end
			REQ_CLEAR: begin
				count = 0;
			end
			default: begin
			end
			endcase
			exp.occ = count[OCC_W-1:0];
			awaited.push_back(exp);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= MISMATCH_REPORTS)
					$display("unexpected result beat: status %0d read_value %h occupancy %0d",
						got.status, got.word, got.occ);
				return;
			end
			exp = awaited.pop_front();
			if (got.status !== exp.status || got.word !== exp.word || got.occ !== exp.occ) begin
				faults++;
				if (faults <= MISMATCH_REPORTS)
					$display("result mismatch: status %0d/%0d read_value %h/%h occupancy %0d/%0d",
						exp.status, got.status, exp.word, got.word, exp.occ, got.occ);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type = '0;
	logic [POS_W-1:0]      position = '0;
	logic [IN_WORD_W-1:0]  write_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [OUT_WORD_W-1:0] read_value;
	logic [OCC_W-1:0]      occupancy;

	bit pace_inputs = 1'b0;
	bit pace_outputs = 1'b0;
	bit hold_off_pending = 1'b0;

	store_scoreboard board = new();

	indexed_sequence_store DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.occupancy   (occupancy)
	);

	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_span();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic request_t make_request(traffic_mix_t mix);
		request_t r;
		int roll;
		int fill;
		fill = board.stored();
		roll = $urandom_range(0, 99);
		case (mix)
		MIX_GROW: begin
			r.kind = roll < 55 ? REQ_INSERT : roll < 70 ? REQ_GET :
				roll < 82 ? REQ_SET : roll < 91 ? REQ_REMOVE : REQ_POP;
		end
		MIX_SHRINK: begin
			r.kind = roll < 20 ? REQ_INSERT : roll < 35 ? REQ_GET :
				roll < 45 ? REQ_SET : roll < 75 ? REQ_REMOVE : REQ_POP;
		end
		MIX_BALANCED: begin
			r.kind = roll < 35 ? REQ_INSERT : roll < 55 ? REQ_GET :
				roll < 70 ? REQ_SET : roll < 83 ? REQ_REMOVE :
				roll < 97 ? REQ_POP : REQ_CLEAR;
		end
		default: begin
			r.kind = REQ_W'($urandom_range(0, 2 ** REQ_W - 1));
		end
		endcase
		// keep most positions inside the stored range so the shifts get exercised
		roll = $urandom_range(0, 99);
		if (mix != MIX_ROUGH && roll < 85)
			r.pos = (fill > 0) ? POS_W'($urandom_range(0, fill - 1)) : '0;
		else
			r.pos = POS_W'($urandom());
		roll = $urandom_range(0, 19);
		if (roll == 0)
			r.value = '0;
		else if (roll == 1)
			r.value = '1;
		else
			r.value = $urandom();
		return r;
	endfunction

	// valid stays high on return so back-to-back beats run without a gap
	task automatic issue_request(request_t r);
		int gap;
		if (pace_inputs && $urandom_range(0, 3) == 0) begin
			gap = idle_span();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		position <= r.pos;
		write_value <= r.value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	always begin : result_pacing
		int span;
		@(posedge clk);
		if (hold_off_pending) begin
			hold_off_pending = 1'b0;
			out_stall <= 1'b1;
			span = HOLD_OFF_CYCLES;
		end else if (pace_outputs && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			span = idle_span();
		end else begin
			out_stall <= 1'b0;
			span = $urandom_range(1, 8);
		end
		repeat (span - 1) @(posedge clk);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(result_t'{status, read_value, occupancy});
	end

	initial begin : stimulus
		traffic_mix_t plan_mix [PHASES] = '{MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_GROW,
			MIX_ROUGH, MIX_BALANCED, MIX_SHRINK};
		int plan_len [PHASES] = '{300, 250, 250, 300, 150, 250, 250};
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		pace_inputs = 1'b1;
		pace_outputs = 1'b1;

		// empty store, refused append, extremes of position and word
		issue_request(request_t'{REQ_POP, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_GET, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_SET, 6'd0, 32'hFFFF_FFFF});
		issue_request(request_t'{REQ_REMOVE, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_INSERT, 6'd1, 32'hFFFF_FFFF});
		issue_request(request_t'{REQ_INSERT, 6'd0, 32'hFFFF_FFFF});
		issue_request(request_t'{REQ_INSERT, 6'd1, 32'h0000_0000});
		issue_request(request_t'{REQ_INSERT, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_INSERT, 6'd1, 32'hA5A5_5A5A});
		issue_request(request_t'{REQ_GET, 6'd63, 32'h0000_0000});
		issue_request(request_t'{REQ_GET, 6'd2, 32'h0000_0000});
		issue_request(request_t'{REQ_SET, 6'd1, 32'h1234_5678});
		issue_request(request_t'{REQ_GET, 6'd1, 32'h0000_0000});
		issue_request(request_t'{REQ_GET, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_REMOVE, 6'd1, 32'h0000_0000});
		issue_request(request_t'{REQ_POP, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_SPARE_A, 6'd63, 32'hFFFF_FFFF});
		issue_request(request_t'{REQ_SPARE_B, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_REMOVE, 6'd63, 32'h0000_0000});
		issue_request(request_t'{REQ_CLEAR, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_GET, 6'd0, 32'h0000_0000});
		issue_request(request_t'{REQ_POP, 6'd0, 32'h0000_0000});

		for (p = 0; p < PHASES; p++) begin
			// phase 3 runs flat out behind a long receiver hold-off
			pace_inputs = (p != 3);
			pace_outputs = (p != 3);
			if (p == 3)
				hold_off_pending = 1'b1;
			if (p == 5)
				drain_results();
			repeat (plan_len[p])
				issue_request(make_request(plan_mix[p]));
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.faults == 0 && board.pending() == 0)
			$display("indexed_sequence_store test passed");
		else
			$display("indexed_sequence_store test failed");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("indexed_sequence_store test failed");
		$finish;
	end

endmodule
